[src/dispersal_neighbor_cell_select_unit_assert.svh]
// Assertion macros for the dispersal neighbor cell select unit.
`ifndef DISPERSAL_NEIGHBOR_CELL_SELECT_UNIT_ASSERT_SVH
`define DISPERSAL_NEIGHBOR_CELL_SELECT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DNCS_ASSERT(label, ante, cons) label: assert property (@(posedge clk) disable iff (rst) \
  (ante) |-> (cons)) else $error("dncs assertion failed");
`define DNCS_ASSERT_NEXT(label, ante, cons) label: assert property (@(posedge clk) \
  disable iff (rst) (ante) |=> (cons)) else $error("dncs assertion failed");
`else
`define DNCS_ASSERT(label, ante, cons)
`define DNCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/dncs_pkg.sv]
package dncs_pkg;
  localparam int unsigned MaxGrid  = 256;
  localparam int unsigned MaxReach = 15;

  localparam logic [1:0] REG_GRID_SIDE  = 2'd0;
  localparam logic [1:0] REG_REACH      = 2'd1;
  localparam logic [1:0] REG_WRAP_EDGES = 2'd2;

  typedef struct packed {
    logic [8:0] side;
    logic [3:0] reach;
    logic       wrap;
  } cfg_t;
endpackage

[src/dncs_coord.sv]
module dncs_coord
  import dncs_pkg::*;
(
  input  cfg_t       cfg,
  input  logic [7:0] pos,
  input  logic [4:0] ofs,
  input  logic [3:0] lo,
  output logic [7:0] dst
);
  logic [14:0] u;
  logic [14:0] step;
  logic [9:0]  lin;

  always_comb begin
    lin = {2'b0, pos} + {5'b0, ofs} - {6'b0, lo};
    u = {7'b0, pos} + {10'b0, ofs} + {2'b0, cfg.side, 4'b0} - {11'b0, cfg.reach};
    for (int k = 5; k >= 0; k--) begin
      step = {6'b0, cfg.side} << k;
      if (u >= step) begin
        u = u - step;
      end
    end
    if (cfg.wrap) begin
      dst = u[7:0];
    end else begin
      dst = lin[7:0];
    end
  end
endmodule

[src/dispersal_neighbor_cell_select_unit.sv]
// Dispersal neighbor cell select unit.
// Input stream s_axis: one item holds a source cell and a 32-bit random
// fraction. Output stream m_axis: one item holds the chosen target cell,
// taken uniformly among the other cells of the square window of reach R
// around the source (wrapped or clipped at the grid edges).
// Configuration goes through the write port cfg_we/cfg_addr/cfg_wdata:
// REG_GRID_SIDE grid side, REG_REACH reach, REG_WRAP_EDGES edge wrapping. Write only while idle.
// The block is a five stage pipeline: window extents, fraction multiply,
// index wrap, row/column divide, coordinate resolve into the output register.
// One item can be accepted every cycle while the output is not stalled. When
// the output register holds an item and m_tready is low, the whole pipeline
// holds and s_tready drops with it.
// Reset clears all valid bits and loads side 16, reach 1 and wrapping edges.
module dispersal_neighbor_cell_select_unit
  import dncs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // src_row[7:0], src_col[15:8], rand_frac[47:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // dst_row[7:0], dst_col[15:8]
);
  `include "dispersal_neighbor_cell_select_unit_assert.svh"

  logic [8:0] grid_side;
  logic [3:0] reach;
  logic       wrap_edges;
  cfg_t       cfg;
  logic       en;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side  <= 9'd16;
      reach      <= 4'd1;
      wrap_edges <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_SIDE:  grid_side  <= cfg_wdata;
        REG_REACH:      reach      <= cfg_wdata[3:0];
        REG_WRAP_EDGES: wrap_edges <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.wrap  = wrap_edges;
    cfg.reach = (reach > 4'(MaxReach)) ? 4'(MaxReach) : reach;
    if (grid_side == 9'd0) begin
      cfg.side = 9'd1;
    end else if (grid_side > 9'(MaxGrid)) begin
      cfg.side = 9'(MaxGrid);
    end else begin
      cfg.side = grid_side;
    end
  end

  logic v1, v2, v3, v4, v5;
  assign en       = !v5 || m_tready;
  assign s_tready = en;

  // Stage 1: clamp and window extents.
  logic [7:0]  x_c, y_c;
  logic [8:0]  hx_full, hy_full;
  logic [3:0]  lox_c, loy_c, hix_c, hiy_c;
  logic [4:0]  xr_c, yr_c;
  logic [9:0]  cnt_c, base_c;
  logic [7:0]  x1, y1;
  logic [3:0]  lox1, loy1;
  logic [4:0]  xr1, yr1;
  logic [9:0]  cnt1, base1;
  logic [31:0] f1;

  always_comb begin
    x_c = ({1'b0, s_tdata[7:0]} >= cfg.side) ? 8'(cfg.side - 9'd1) : s_tdata[7:0];
    y_c = ({1'b0, s_tdata[15:8]} >= cfg.side) ? 8'(cfg.side - 9'd1) : s_tdata[15:8];
    hx_full = cfg.side - 9'd1 - {1'b0, x_c};
    hy_full = cfg.side - 9'd1 - {1'b0, y_c};
    if (cfg.wrap) begin
      lox_c = cfg.reach;
      loy_c = cfg.reach;
      hix_c = cfg.reach;
      hiy_c = cfg.reach;
    end else begin
      lox_c = (x_c < {4'b0, cfg.reach}) ? x_c[3:0] : cfg.reach;
      loy_c = (y_c < {4'b0, cfg.reach}) ? y_c[3:0] : cfg.reach;
      hix_c = (hx_full < {5'b0, cfg.reach}) ? hx_full[3:0] : cfg.reach;
      hiy_c = (hy_full < {5'b0, cfg.reach}) ? hy_full[3:0] : cfg.reach;
    end
    xr_c   = {1'b0, lox_c} + {1'b0, hix_c} + 5'd1;
    yr_c   = {1'b0, loy_c} + {1'b0, hiy_c} + 5'd1;
    cnt_c  = {5'b0, xr_c} * {5'b0, yr_c};
    base_c = {5'b0, yr_c} * {6'b0, lox_c} + {6'b0, loy_c} + 10'd1;
  end

  // Stage 2: pick index from the fraction.
  logic [41:0] prod_c;
  logic [9:0]  p2, cnt2, base2;
  logic [7:0]  x2, y2;
  logic [3:0]  lox2, loy2;
  logic [4:0]  xr2, yr2;
  assign prod_c = {32'b0, cnt1 - 10'd1} * {10'b0, f1};

  // Stage 3: wrap the cell index into the window.
  logic [10:0] sum_c;
  logic [9:0]  s_c, s3, cnt3;
  logic [7:0]  x3, y3;
  logic [3:0]  lox3, loy3;
  logic [4:0]  xr3, yr3;
  always_comb begin
    sum_c = {1'b0, base2} + {1'b0, p2};
    s_c   = (sum_c >= {1'b0, cnt2}) ? 10'(sum_c - {1'b0, cnt2}) : sum_c[9:0];
  end

  // Stage 4: split the index into row and column offsets.
  logic [9:0]  rem_c, dsub;
  logic [4:0]  q_c;
  logic [4:0]  q4, r4, xr4, yr4;
  logic [7:0]  x4, y4;
  logic [3:0]  lox4, loy4;
  always_comb begin
    rem_c = s3;
    q_c   = 5'd0;
    for (int i = 4; i >= 0; i--) begin
      dsub = {5'b0, yr3} << i;
      if (rem_c >= dsub) begin
        rem_c = rem_c - dsub;
        q_c[i] = 1'b1;
      end
    end
  end

  // Stage 5: resolve coordinates into the output register.
  logic [7:0] row_c, col_c;
  logic [7:0] dst_row, dst_col;
  dncs_coord u_row (.cfg(cfg), .pos(x4), .ofs(q4), .lo(lox4), .dst(row_c));
  dncs_coord u_col (.cfg(cfg), .pos(y4), .ofs(r4), .lo(loy4), .dst(col_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x_c; y1 <= y_c; lox1 <= lox_c; loy1 <= loy_c;
      xr1 <= xr_c; yr1 <= yr_c; cnt1 <= cnt_c; base1 <= base_c;
      f1 <= s_tdata[47:16];

      p2 <= prod_c[41:32]; cnt2 <= cnt1; base2 <= base1;
      x2 <= x1; y2 <= y1; lox2 <= lox1; loy2 <= loy1; xr2 <= xr1; yr2 <= yr1;

      s3 <= s_c; cnt3 <= cnt2;
      x3 <= x2; y3 <= y2; lox3 <= lox2; loy3 <= loy2; xr3 <= xr2; yr3 <= yr2;

      q4 <= q_c; r4 <= rem_c[4:0]; xr4 <= xr3; yr4 <= yr3;
      x4 <= x3; y4 <= y3; lox4 <= lox3; loy4 <= loy3;

      dst_row <= row_c;
      dst_col <= col_c;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {dst_col, dst_row};

  `DNCS_ASSERT(a_base_in_window, v1, base1 <= cnt1)
  `DNCS_ASSERT(a_index_wrapped, v3, s3 < cnt3)
  `DNCS_ASSERT(a_offsets_in_window, v4, (q4 < xr4) && (r4 < yr4))
  `DNCS_ASSERT_NEXT(a_stall_holds, v4 && !en, v4 && $stable(q4) && $stable(r4))
endmodule

[test/tb_dispersal_neighbor_cell_select_unit.sv]
`timescale 1ns / 100ps

class target_cell_board;
  logic [15:0] pending[$];
  int errors;
  logic [8:0] side;
  logic [3:0] reach;
  logic       wrap;

  function new();
    errors = 0;
    side = 16;
    reach = 1;
    wrap = 1;
  endfunction

  function logic [15:0] pick_target(logic [7:0] row, logic [7:0] col, logic [31:0] frac);
    int unsigned sd, r, x, y, len, k, s, nx, ny, lox, loy, xr, yr, cnt, idx;
    longint unsigned prod;
    sd = side;
    r = reach;
    x = row;
    y = col;
    if (sd < 1) sd = 1;
    if (sd > dncs_pkg::MaxGrid) sd = dncs_pkg::MaxGrid;
    if (r > dncs_pkg::MaxReach) r = dncs_pkg::MaxReach;
    if (x >= sd) x = sd - 1;
    if (y >= sd) y = sd - 1;
    if (wrap) begin
      len = 2 * r + 1;
      k = len * len;
      prod = longint'(k - 1) * longint'(frac);
      idx = 32'(prod >> 32);
      s = ((k + 1) / 2 + idx) % k;
      nx = (r * sd + x + s / len - r) % sd;
      ny = (r * sd + y + s % len - r) % sd;
    end else begin
      lox = (x < r) ? x : r;
      loy = (y < r) ? y : r;
      xr = lox + (((sd - 1 - x) < r) ? (sd - 1 - x) : r) + 1;
      yr = loy + (((sd - 1 - y) < r) ? (sd - 1 - y) : r) + 1;
      cnt = xr * yr;
      prod = longint'(cnt - 1) * longint'(frac);
      idx = 32'(prod >> 32);
      s = (yr * lox + loy + 1 + idx) % cnt;
      nx = x + s / yr - lox;
      ny = y + s % yr - loy;
    end
    return {ny[7:0], nx[7:0]};
  endfunction

  function void note_source(logic [47:0] d);
    pending = {pending, pick_target(d[7:0], d[15:8], d[47:16])};
  endfunction

  function void check_target(logic [15:0] got);
    logic [15:0] exp_cell;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    exp_cell = pending.pop_front();
    if (exp_cell[7:0] !== got[7:0]) begin
      $display("%0t: dst_row expected %0d actual %0d", $time, exp_cell[7:0], got[7:0]);
      errors++;
    end
    if (exp_cell[15:8] !== got[15:8]) begin
      $display("%0t: dst_col expected %0d actual %0d", $time, exp_cell[15:8], got[15:8]);
      errors++;
    end
  endfunction
endclass

module tb_dispersal_neighbor_cell_select_unit;
  import dncs_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = 0;
  logic [8:0]  cfg_wdata = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;

  target_cell_board board = new();
  longint cycles = 0;
  bit stall_on = 0;

  dispersal_neighbor_cell_select_unit dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) board.note_source(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_target(m_tdata);
  end

  always @(negedge clk) begin
    if (!stall_on) m_tready <= 1;
    else m_tready <= (cycles % 7 < 3) || ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic configure(logic [8:0] sd, logic [3:0] r, logic w);
    write_reg(REG_GRID_SIDE, sd);
    write_reg(REG_REACH, r);
    write_reg(REG_WRAP_EDGES, w);
    board.side = sd;
    board.reach = r;
    board.wrap = w;
  endtask

  task automatic send_source(logic [7:0] row, logic [7:0] col, logic [31:0] frac);
    s_tvalid <= 1;
    s_tdata <= {frac, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int burst;
    int sd;
    sd = board.side;
    if (sd < 1) sd = 1;
    if (sd > 256) sd = 256;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0)
          send_source(8'($urandom), 8'($urandom), $urandom);
        else
          send_source(8'($urandom_range(0, sd - 1)), 8'($urandom_range(0, sd - 1)),
                      $urandom);
        n--;
      end
      s_tvalid <= 0;
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    s_tvalid <= 0;
  endtask

  logic [8:0] sides[8] = '{1, 2, 3, 16, 37, 255, 256, 0};

  initial begin
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_source(0, 0, 0);
    send_source(15, 15, 32'hFFFF_FFFF);
    s_tvalid <= 0;
    drain();
    configure(256, 15, 1);
    send_source(0, 0, 32'hFFFF_FFFF);
    send_source(255, 255, 0);
    send_source(8'hAA, 8'h55, 32'h8000_0000);
    s_tvalid <= 0;
    drain();
    configure(256, 15, 0);
    send_source(0, 0, 32'hFFFF_FFFF);
    send_source(255, 255, 32'h0);
    send_source(255, 0, 32'h7FFF_FFFF);
    send_source(128, 128, 32'hFFFF_FFFF);
    s_tvalid <= 0;
    drain();
    configure(16, 0, 1);
    send_source(3, 4, 32'hDEAD_BEEF);
    s_tvalid <= 0;
    drain();
    configure(1, 3, 0);
    send_source(0, 0, 32'h1234_5678);
    send_source(200, 9, 32'hFFFF_FFFF);
    s_tvalid <= 0;
    drain();
    configure(3, 15, 1);
    send_source(1, 2, 32'hFFFF_FFFF);
    send_source(250, 0, 0);
    s_tvalid <= 0;
    drain();
    configure(0, 2, 1);
    send_source(5, 5, 32'h4000_0000);
    s_tvalid <= 0;
    drain();
    configure(9'h1FF, 4'hF, 0);
    send_source(255, 1, 32'hFFFF_FFFF);
    s_tvalid <= 0;
    drain();
    for (int p = 0; p < 16; p++) begin
      configure(9'(sides[$urandom_range(0, 7)] ^ ((p > 7) ? $urandom_range(0, 300) : 0)),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      stall_on = (p % 3) != 0;
      random_phase(120);
      drain();
    end
    stall_on = 0;
    drain();
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/dncs_pkg.sv
src/dncs_coord.sv
src/dispersal_neighbor_cell_select_unit.sv
test/tb_dispersal_neighbor_cell_select_unit.sv
